FILE: hdl/ows_pkg.sv
`timescale 1ns / 1ps

package ows_pkg;

    localparam int ROM_BITS     = 64;
    localparam int POS_W        = 7;
    localparam int LFD_W        = 4;
    localparam int FAMILY_LIMIT = 9;
    localparam int CMD_W        = 8;

    localparam logic [7:0] CRC_POLY       = 8'h8C;
    localparam logic [7:0] SEARCH_CMD_RST = 8'hF0;

    typedef enum logic [2:0] {
        OP_FIRST    = 3'd0,
        OP_NEXT     = 3'd1,
        OP_TARGET   = 3'd2,
        OP_SKIP     = 3'd3,
        OP_VERIFY   = 3'd4,
        OP_PRESENCE = 3'd5,
        OP_BIT_PAIR = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        REQ_NONE      = 2'd0,
        REQ_RESET     = 2'd1,
        REQ_COMMAND   = 2'd2,
        REQ_DIRECTION = 2'd3
    } bus_req_t;

    // reflected crc-8, poly 0x8c, one byte lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ d[0];
            c   = c >> 1;
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return c;
    endfunction

endpackage

FILE: hdl/onewire_rom_search_engine_top.sv
`timescale 1ns / 1ps

// channel | signals                                                   | role
// cfg     | cfg_valid, cfg_ready, cfg_data                            | search command write
// in      | in_valid, in_ready, operation .. complement_bit           | command or bus event
// out     | out_valid, out_ready, bus_request .. status               | bus request and result
//
// one item per cycle while the output is not stalled; the result is registered in the output register on the transfer
// all decisions and the crc-8 byte update sit between the state and the output register
// in_ready is high while the output register is empty or being taken, so a stalled
// output holds the next item off; cfg_ready is always high
// reset sets search_command to 0xf0, clears the search state and empties the output

module onewire_rom_search_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ows_pkg::CMD_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       operation,
    input  logic [7:0]                       family_byte,
    input  logic [ows_pkg::ROM_BITS-1:0]     device_id,
    input  logic                             presence,
    input  logic                             id_bit,
    input  logic                             complement_bit,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       bus_request,
    output logic [ows_pkg::CMD_W-1:0]        command_byte,
    output logic                             direction,
    output logic                             done_res,
    output logic                             found,
    output logic [ows_pkg::ROM_BITS-1:0]     rom_id,
    output logic                             matches_res,
    output logic                             status
);

    import ows_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESENCE = 2'd1,
        PH_BITS     = 2'd2
    } phase_t;

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(ROM_BITS);
    localparam logic [POS_W-1:0] POS_FAMILY = POS_W'(FAMILY_LIMIT);

    logic [CMD_W-1:0]    search_cmd_reg;
    logic [ROM_BITS-1:0] rom_reg, rom_next;
    logic [ROM_BITS-1:0] verify_reg, verify_next;
    logic [POS_W-1:0]    ld_reg, ld_next;
    logic [LFD_W-1:0]    lfd_reg, lfd_next;
    logic                ldf_reg, ldf_next;
    logic [POS_W-1:0]    lzp_reg, lzp_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]          crc_reg, crc_next;
    phase_t              phase_reg, phase_next;
    logic                verifying_reg, verifying_next;

    logic                out_valid_reg;
    bus_req_t            req_reg, req_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic                dir_reg, dir_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;
    logic                match_reg, match_next;
    logic                ignored_reg, ignored_next;

    logic                accept;
    logic                do_start;
    logic                do_finish;
    logic                finish_ok;
    logic                good;
    logic [5:0]          idx;
    logic                dir;
    op_t                 op;

    assign op        = op_t'(operation);
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        rom_next       = rom_reg;
        verify_next    = verify_reg;
        ld_next        = ld_reg;
        lfd_next       = lfd_reg;
        ldf_next       = ldf_reg;
        lzp_next       = lzp_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        phase_next     = phase_reg;
        verifying_next = verifying_reg;
        req_next       = REQ_NONE;
        cmd_next       = '0;
        dir_next       = 1'b0;
        done_next      = 1'b0;
        found_next     = 1'b0;
        match_next     = 1'b0;
        ignored_next   = 1'b0;
        do_start       = 1'b0;
        do_finish      = 1'b0;
        finish_ok      = 1'b0;
        good           = 1'b0;
        idx            = pos_reg[5:0] - 6'd1;
        dir            = 1'b0;

        if (operation inside {[OP_FIRST:OP_VERIFY]})
        begin
            if (phase_reg != PH_IDLE)
            begin
                ignored_next = 1'b1;
            end
            else
            begin
                case (op)
                    OP_FIRST:
                    begin
                        ld_next  = '0;
                        lfd_next = '0;
                        ldf_next = 1'b0;
                        do_start = 1'b1;
                    end
                    OP_NEXT:
                    begin
                        do_start = 1'b1;
                    end
                    OP_TARGET:
                    begin
                        rom_next = ROM_BITS'(family_byte);
                        ld_next  = POS_LAST;
                        lfd_next = '0;
                        ldf_next = 1'b0;
                    end
                    OP_SKIP:
                    begin
                        ld_next  = POS_W'(lfd_reg);
                        lfd_next = '0;
                        if (lfd_reg == '0)
                        begin
                            ldf_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        rom_next       = device_id;
                        verify_next    = device_id;
                        ld_next        = POS_LAST;
                        ldf_next       = 1'b0;
                        verifying_next = 1'b1;
                        do_start       = 1'b1;
                    end
                endcase
            end
        end
        else if (op == OP_PRESENCE && phase_reg == PH_PRESENCE)
        begin
            if (presence)
            begin
                req_next   = REQ_COMMAND;
                cmd_next   = search_cmd_reg;
                phase_next = PH_BITS;
            end
            else
            begin
                do_finish = 1'b1;
            end
        end
        else if (op == OP_BIT_PAIR && phase_reg == PH_BITS)
        begin
            if (id_bit && complement_bit)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                if (id_bit != complement_bit)
                begin
                    dir = id_bit;
                end
                else
                begin
                    if (pos_reg < ld_reg)
                    begin
                        dir = rom_reg[idx];
                    end
                    else
                    begin
                        dir = (pos_reg == ld_reg);
                    end
                    if (!dir)
                    begin
                        lzp_next = pos_reg;
                        if (pos_reg < POS_FAMILY)
                        begin
                            lfd_next = pos_reg[LFD_W-1:0];
                        end
                    end
                end
                rom_next[idx] = dir;
                req_next      = REQ_DIRECTION;
                dir_next      = dir;
                if (idx[2:0] == 3'd7)
                begin
                    crc_next = crc8_byte(crc_reg, rom_next[{idx[5:3], 3'b000} +: 8]);
                end
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg >= POS_LAST)
                begin
                    do_finish = 1'b1;
                    finish_ok = (crc_next == 8'd0);
                end
            end
        end
        else
        begin
            ignored_next = 1'b1;
        end

        if (do_start)
        begin
            crc_next = '0;
            pos_next = POS_W'(1);
            lzp_next = '0;
            if (ldf_next)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                req_next   = REQ_RESET;
                phase_next = PH_PRESENCE;
            end
        end

        if (do_finish)
        begin
            good = finish_ok && (rom_next[7:0] != 8'd0);
            if (finish_ok)
            begin
                ld_next = lzp_next;
                if (lzp_next == '0)
                begin
                    ldf_next = 1'b1;
                end
            end
            if (!good)
            begin
                ld_next  = '0;
                lfd_next = '0;
                ldf_next = 1'b0;
            end
            done_next      = 1'b1;
            found_next     = good;
            match_next     = verifying_next && good && (rom_next == verify_next);
            verifying_next = 1'b0;
            phase_next     = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_cmd_reg <= SEARCH_CMD_RST;
            rom_reg        <= '0;
            verify_reg     <= '0;
            ld_reg         <= '0;
            lfd_reg        <= '0;
            ldf_reg        <= 1'b0;
            lzp_reg        <= '0;
            pos_reg        <= POS_W'(1);
            crc_reg        <= '0;
            phase_reg      <= PH_IDLE;
            verifying_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            req_reg        <= REQ_NONE;
            cmd_reg        <= '0;
            dir_reg        <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            match_reg      <= 1'b0;
            ignored_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                search_cmd_reg <= cfg_data;
            end
            if (accept)
            begin
                rom_reg       <= rom_next;
                verify_reg    <= verify_next;
                ld_reg        <= ld_next;
                lfd_reg       <= lfd_next;
                ldf_reg       <= ldf_next;
                lzp_reg       <= lzp_next;
                pos_reg       <= pos_next;
                crc_reg       <= crc_next;
                phase_reg     <= phase_next;
                verifying_reg <= verifying_next;
                req_reg       <= req_next;
                cmd_reg       <= cmd_next;
                dir_reg       <= dir_next;
                done_reg      <= done_next;
                found_reg     <= found_next;
                match_reg     <= match_next;
                ignored_reg   <= ignored_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign bus_request  = req_reg;
    assign command_byte = cmd_reg;
    assign direction    = dir_reg;
    assign done_res     = done_reg;
    assign found        = found_reg;
    assign rom_id       = rom_reg;
    assign matches_res  = match_reg;
    assign status       = ignored_reg;

`ifndef ASSERT_OFF
    a_bit_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BITS |-> (pos_reg >= POS_W'(1) && pos_reg <= POS_LAST))
        else $error("bit position out of range while taking bit pairs");

    a_family_limit: assert property (@(posedge clk) disable iff (!rst_n)
        POS_W'(lfd_reg) < POS_FAMILY)
        else $error("family discrepancy beyond family byte");

    a_last_device: assert property (@(posedge clk) disable iff (!rst_n)
        ldf_reg |-> ld_reg == '0)
        else $error("last device flag with nonzero last discrepancy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> phase_reg == PH_IDLE)
        else $error("pass ended but phase not idle");

    a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && match_reg |-> found_reg && done_reg)
        else $error("verify match without found device");
`endif

endmodule
